/* src/dhst_pkg.sv */
package dhst_pkg;

    localparam int CMD_W      = 2;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Reported mode codes
    localparam logic [MODE_W-1:0] MODE_CODE_NORMAL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_UNSTABLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CODE_DOWN     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_AFTER_SECONDS = 2'd2;

    localparam logic [COUNT_W-1:0] ERROR_THRESHOLD_RST    = 8'd3;
    localparam logic [COUNT_W-1:0] SUCCESS_THRESHOLD_RST  = 8'd10;
    localparam logic [TIME_W-1:0]  DOWN_AFTER_SECONDS_RST = 32'd1800;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUCCESS = 2'd0,
        CMD_ERROR   = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_NORMAL   = 3'b001,
        ST_UNSTABLE = 3'b010,
        ST_DOWN     = 3'b100
    } mode_t;

    typedef struct packed {
        logic [COUNT_W-1:0] error_threshold;
        logic [COUNT_W-1:0] success_threshold;
        logic [TIME_W-1:0]  down_after_seconds;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] disk_mode;
        logic              mode_changed;
    } result_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        case (m)
            ST_NORMAL:   code = MODE_CODE_NORMAL;
            ST_UNSTABLE: code = MODE_CODE_UNSTABLE;
            default:     code = MODE_CODE_DOWN;
        endcase
        return code;
    endfunction

endpackage

/* src/dhst_cfg_regs.sv */
module dhst_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dhst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dhst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dhst_pkg::cfg_t                   cfg
);
    import dhst_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ERROR_THRESHOLD:    cfg_next.error_threshold    = cfg_data[COUNT_W-1:0];
                CFG_SUCCESS_THRESHOLD:  cfg_next.success_threshold  = cfg_data[COUNT_W-1:0];
                CFG_DOWN_AFTER_SECONDS: cfg_next.down_after_seconds = cfg_data[TIME_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.error_threshold    <= ERROR_THRESHOLD_RST;
            cfg_reg.success_threshold  <= SUCCESS_THRESHOLD_RST;
            cfg_reg.down_after_seconds <= DOWN_AFTER_SECONDS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/dhst_health_fsm.sv */
module dhst_health_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [dhst_pkg::CMD_W-1:0]     command,
    input  logic [dhst_pkg::TIME_W-1:0]    now_seconds,
    input  dhst_pkg::cfg_t                 cfg,
    output dhst_pkg::result_t              result
);
    import dhst_pkg::*;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [COUNT_W-1:0] error_count_reg;
    logic [COUNT_W-1:0] error_count_next;
    logic [COUNT_W-1:0] success_count_reg;
    logic [COUNT_W-1:0] success_count_next;
    logic [TIME_W-1:0]  unstable_since_reg;
    logic [TIME_W-1:0]  unstable_since_next;

    logic [COUNT_W-1:0] error_inc;
    logic [COUNT_W-1:0] success_inc;
    logic [TIME_W-1:0]  elapsed;
    logic               changed;

    assign error_inc   = (error_count_reg == COUNT_MAX) ? COUNT_MAX : error_count_reg + 1'b1;
    assign success_inc = (success_count_reg == COUNT_MAX) ? COUNT_MAX : success_count_reg + 1'b1;
    // wraps modulo 2^32, so a clock that steps back reads as a long time
    assign elapsed     = now_seconds - unstable_since_reg;

    always_comb
    begin
        mode_next           = mode_reg;
        error_count_next    = error_count_reg;
        success_count_next  = success_count_reg;
        unstable_since_next = unstable_since_reg;
        changed             = 1'b0;
        case (mode_reg)
            ST_NORMAL:
            begin
                case (cmd_t'(command))
                    CMD_ERROR:
                    begin
                        error_count_next = error_inc;
                        if (error_inc > cfg.error_threshold)
                        begin
                            mode_next           = ST_UNSTABLE;
                            error_count_next    = '0;
                            success_count_next  = '0;
                            unstable_since_next = now_seconds;
                            changed             = 1'b1;
                        end
                    end
                    CMD_TICK: error_count_next = '0;
                    default:  mode_next = mode_reg;
                endcase
            end
            ST_UNSTABLE:
            begin
                case (cmd_t'(command))
                    CMD_SUCCESS:
                    begin
                        success_count_next = success_inc;
                        if (success_inc > cfg.success_threshold)
                        begin
                            mode_next          = ST_NORMAL;
                            error_count_next   = '0;
                            success_count_next = '0;
                            changed            = 1'b1;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (elapsed > cfg.down_after_seconds)
                        begin
                            mode_next          = ST_DOWN;
                            error_count_next   = '0;
                            success_count_next = '0;
                            changed            = 1'b1;
                        end
                        else
                        begin
                            success_count_next = '0;
                        end
                    end
                    default: mode_next = mode_reg;
                endcase
            end
            default: mode_next = mode_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= ST_NORMAL;
            error_count_reg    <= '0;
            success_count_reg  <= '0;
            unstable_since_reg <= '0;
        end
        else if (step)
        begin
            mode_reg           <= mode_next;
            error_count_reg    <= error_count_next;
            success_count_reg  <= success_count_next;
            unstable_since_reg <= unstable_since_next;
        end
    end

    assign result.disk_mode    = mode_code(mode_next);
    assign result.mode_changed = changed;

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(error_count_reg) && $stable(success_count_reg))
        else $error("tracker state moved without a transaction");

    a_down_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ST_DOWN |=> mode_reg == ST_DOWN)
        else $error("left down mode");

    a_unstable_no_errors: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ST_UNSTABLE |-> error_count_reg == '0)
        else $error("error count nonzero in unstable mode");

    a_normal_no_successes: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ST_NORMAL |-> success_count_reg == '0)
        else $error("success count nonzero in normal mode");

    a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.mode_changed |=> mode_reg != $past(mode_reg))
        else $error("mode_changed set but mode held");

endmodule

/* src/disk_health_state_tracker_top.sv */
// An accepted transaction goes from the input register through the health state update into the
// result register at out_*. Throughput: one transaction per cycle unless out_ready stalls; the input
// and result registers advance with the state update, which feeds the next item with no bubble.
// Reset (rst_n, async, active low): mode normal, counters and entry time zero, thresholds 3 and
// 10, down limit 1800 s; both pipeline registers empty.
module disk_health_state_tracker_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dhst_pkg::CMD_W-1:0]       command,
    input  logic [dhst_pkg::TIME_W-1:0]      now_seconds,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dhst_pkg::MODE_W-1:0]      disk_mode,
    output logic                             mode_changed,
    input  logic                             cfg_we,
    input  logic [dhst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dhst_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dhst_pkg::*;

    logic              in_valid_reg;
    logic [CMD_W-1:0]  command_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    result_t           result;
    cfg_t              cfg;
    logic              step;

    // advance when the input register holds a transaction and the result slot frees up
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    dhst_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dhst_health_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .command     (command_reg),
        .now_seconds (now_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            command_reg <= command;
            now_reg     <= now_seconds;
        end
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign disk_mode    = result_reg.disk_mode;
    assign mode_changed = result_reg.mode_changed;

    a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed transaction did not reach the result register");

    a_stalled_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(command_reg) && $stable(now_reg))
        else $error("pending input transaction lost while stalled");

endmodule

/* tb/disk_health_checker.sv */
`timescale 1ns / 100ps

module disk_health_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [dhst_pkg::CMD_W-1:0]       command,
    input  logic [dhst_pkg::TIME_W-1:0]      now_seconds,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [dhst_pkg::MODE_W-1:0]      disk_mode,
    input  logic                             mode_changed,
    input  logic                             cfg_we,
    input  logic [dhst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dhst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatch_total,
    output int                               open_reports
);
    import dhst_pkg::*;

    logic [MODE_W-1:0]  mode_now;
    logic [COUNT_W-1:0] error_run;
    logic [COUNT_W-1:0] success_run;
    logic [COUNT_W-1:0] error_limit;
    logic [COUNT_W-1:0] success_limit;
    logic [TIME_W-1:0]  unstable_at;
    logic [TIME_W-1:0]  down_limit;
    result_t            pending_reports[$];

    // Advance the health state by one event and form the report it produces.
    task automatic apply_health_event(input logic [CMD_W-1:0] cmd,
                                      input logic [TIME_W-1:0] now,
                                      output result_t report);
        logic              changed;
        logic [TIME_W-1:0] elapsed;
        changed = 1'b0;
        case (mode_now)
            MODE_CODE_NORMAL:
            begin
                if (cmd == CMD_ERROR)
                begin
                    if (error_run != COUNT_MAX)
                        error_run = error_run + 1'b1;
                    if (error_run > error_limit)
                    begin
                        mode_now    = MODE_CODE_UNSTABLE;
                        error_run   = '0;
                        success_run = '0;
                        unstable_at = now;
                        changed     = 1'b1;
                    end
                end
                else if (cmd == CMD_TICK)
                    error_run = '0;
            end
            MODE_CODE_UNSTABLE:
            begin
                if (cmd == CMD_SUCCESS)
                begin
                    if (success_run != COUNT_MAX)
                        success_run = success_run + 1'b1;
                    if (success_run > success_limit)
                    begin
                        mode_now    = MODE_CODE_NORMAL;
                        error_run   = '0;
                        success_run = '0;
                        changed     = 1'b1;
                    end
                end
                else if (cmd == CMD_TICK)
                begin
                    // wraps at 32 bits, so a clock stepping back reads as a long stay
                    elapsed = now - unstable_at;
                    if (elapsed > down_limit)
                    begin
                        mode_now    = MODE_CODE_DOWN;
                        error_run   = '0;
                        success_run = '0;
                        changed     = 1'b1;
                    end
                    else
                        success_run = '0;
                end
            end
            default:
            begin
            end
        endcase
        report.disk_mode    = (mode_now > MODE_CODE_DOWN) ? MODE_CODE_DOWN : mode_now;
        report.mode_changed = changed;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            mode_now       = MODE_CODE_NORMAL;
            error_run      = '0;
            success_run    = '0;
            unstable_at    = '0;
            error_limit    = ERROR_THRESHOLD_RST;
            success_limit  = SUCCESS_THRESHOLD_RST;
            down_limit     = DOWN_AFTER_SECONDS_RST;
            pending_reports.delete();
            mismatch_total = 0;
            open_reports   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.disk_mode    = disk_mode;
                got.mode_changed = mode_changed;
                if (pending_reports.size() == 0)
                begin
                    if (mismatch_total < 10)
                        $display("%0t: unexpected result mode %0d changed %0b",
                                 $realtime, got.disk_mode, got.mode_changed);
                    mismatch_total++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (want.disk_mode !== got.disk_mode ||
                        want.mode_changed !== got.mode_changed)
                    begin
                        if (mismatch_total < 10)
                            $display("%0t: mismatch mode exp %0d got %0d, changed exp %0b got %0b",
                                     $realtime, want.disk_mode, got.disk_mode,
                                     want.mode_changed, got.mode_changed);
                        mismatch_total++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ERROR_THRESHOLD:    error_limit   = cfg_data[COUNT_W-1:0];
                    CFG_SUCCESS_THRESHOLD:  success_limit = cfg_data[COUNT_W-1:0];
                    CFG_DOWN_AFTER_SECONDS: down_limit    = cfg_data[TIME_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                apply_health_event(command, now_seconds, want);
                pending_reports.push_back(want);
            end
            open_reports = pending_reports.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import dhst_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CMD_W-1:0]      command;
    logic [TIME_W-1:0]     now_seconds;
    logic                  out_valid;
    logic                  out_ready;
    logic [MODE_W-1:0]     disk_mode;
    logic                  mode_changed;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatch_total;
    int                    open_reports;
    logic                  steady;
    logic [TIME_W-1:0]     wall_clock;

    disk_health_state_tracker_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .now_seconds  (now_seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .disk_mode    (disk_mode),
        .mode_changed (mode_changed),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    disk_health_checker health_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .now_seconds    (now_seconds),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .disk_mode      (disk_mode),
        .mode_changed   (mode_changed),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_total (mismatch_total),
        .open_reports   (open_reports)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #800000;
        $display("testbench NOT OK");
        $finish;
    end

    // receiver stalls at random unless a steady stretch is running
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 22);

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] stamp);
        while (!steady && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        now_seconds <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding report has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (open_reports != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic load_config(input logic [COUNT_W-1:0] err_lim,
                               input logic [COUNT_W-1:0] ok_lim,
                               input logic [TIME_W-1:0]  down_lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ERROR_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(err_lim);
        @(negedge clk);
        cfg_index <= CFG_SUCCESS_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(ok_lim);
        @(negedge clk);
        cfg_index <= CFG_DOWN_AFTER_SECONDS;
        cfg_data  <= CFG_DATA_W'(down_lim);
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(input logic [CMD_W-1:0] major);
        int               roll;
        logic [CMD_W-1:0] cmd;
        roll = $urandom_range(99);
        if (roll < 80)
            cmd = major;
        else if (roll < 88)
            cmd = CMD_TICK;
        else if (roll < 96)
            cmd = (major == CMD_ERROR) ? CMD_SUCCESS : CMD_ERROR;
        else
            cmd = CMD_UNUSED;
        return cmd;
    endfunction

    // Bursts dominated by one command, with ticks, opposite events and unused codes mixed in.
    task automatic run_traffic(input int count, input bit wild_time);
        int               sent;
        int               len;
        int               roll;
        logic [CMD_W-1:0] major;
        logic [TIME_W-1:0] stamp;
        sent = 0;
        while (sent < count)
        begin
            roll  = $urandom_range(99);
            major = (roll < 45) ? CMD_ERROR : (roll < 90) ? CMD_SUCCESS : CMD_TICK;
            len   = $urandom_range(2, 16);
            repeat (len)
            begin
                if (wild_time)
                    stamp = $urandom();
                else
                begin
                    wall_clock = wall_clock + $urandom_range(3);
                    stamp      = wall_clock;
                end
                send_event(pick_command(major), stamp);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_SUCCESS;
        now_seconds = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_ERROR_THRESHOLD;
        cfg_data    = '0;
        steady      = 1'b0;
        wall_clock  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset thresholds 3 / 10, limit 1800 s
        send_event(CMD_SUCCESS, 32'd0);
        send_event(CMD_UNUSED, TIME_MAX);
        repeat (3) send_event(CMD_ERROR, 32'd5);
        send_event(CMD_TICK, 32'd6);
        repeat (4) send_event(CMD_ERROR, 32'hFFFF_FFF0);
        send_event(CMD_ERROR, 32'hFFFF_FFF1);
        send_event(CMD_UNUSED, 32'hFFFF_FFF2);
        send_event(CMD_SUCCESS, 32'h5555_5555);
        // exactly at the limit across the wrap: stay unstable
        send_event(CMD_TICK, 32'h0000_06F8);
        for (int i = 0; i < 11; i++)
            send_event(CMD_SUCCESS, 32'hAAAA_AAAA ^ i);

        // moderate thresholds, wall clock advancing far less than any limit
        wall_clock = $urandom();
        repeat (4)
        begin
            settle();
            load_config(COUNT_W'($urandom_range(1, 6)), COUNT_W'($urandom_range(1, 8)),
                        TIME_W'($urandom_range(5000, 1000000)));
            run_traffic(100, 1'b0);
        end

        // zero thresholds, open-ended limit, no idling on either side
        settle();
        load_config(8'd0, 8'd0, TIME_MAX);
        steady = 1'b1;
        run_traffic(300, 1'b1);
        send_event(CMD_SUCCESS, $urandom());
        steady = 1'b0;

        // thresholds of 254: counters run up to their saturation value, 255, before the mode changes
        settle();
        load_config(8'd254, 8'd254, TIME_MAX);
        repeat (256) send_event(CMD_ERROR, $urandom());
        repeat (256) send_event(CMD_SUCCESS, $urandom());

        // zero limit, then a clock stepping back; the rest lands in down
        settle();
        load_config(8'd1, 8'd3, '0);
        run_traffic(60, 1'b0);
        repeat (2) send_event(CMD_ERROR, wall_clock);
        send_event(CMD_TICK, wall_clock - 1'b1);
        run_traffic(60, 1'b1);

        settle();
        repeat (8) @(negedge clk);
        if (mismatch_total == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
src/dhst_pkg.sv
src/dhst_cfg_regs.sv
src/dhst_health_fsm.sv
src/disk_health_state_tracker_top.sv
tb/disk_health_checker.sv
tb/testbench.sv
